FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker module of the block allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, codes and types shared by the bitmap block allocator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int TOTAL_W    = 13;
  localparam int BLOCK_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = BIT_W + 1;
  localparam int CMP_W      = ((TOTAL_W > WORD_AW + BIT_W) ? TOTAL_W : WORD_AW + BIT_W) + 2;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = TOTAL_W'(4096);
  localparam logic                REG_TOTAL    = 1'b0;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DFREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
    logic             last;
  } eval_t;

endpackage

FILE: rtl/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a used/free bitmap held in a word RAM.
// ----------------------------------------------------------------------------
// A free reads the addressed bitmap word in the scan state; an allocate scans the
// 64-bit bitmap words from word 0 on (up to 64 of them). The result is then registered.
// The single RAM read port sets the scan rate of one word per cycle.
// A new start is taken in the cycle the result strobe is high.
// Reset clears the per-word valid bits at once, so the bitmap reads as all free.
`timescale 1ns / 1ps

module bitmap_block_allocator_core
  import bba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [BLOCK_W-1:0]  in_block_number,
  output logic                out_valid,
  output logic [BLOCK_W-1:0]  out_granted_block,
  output logic [STATUS_W-1:0] out_status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  fsm_t                 state_r, state_nxt;
  logic [WORD_AW-1:0]   addr_r, addr_nxt;
  logic                 mode_r;
  logic [BLOCK_W-1:0]   bn_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [MAP_WORDS-1:0] valid_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]   granted_r, granted_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic                 accept;
  logic                 cfg_wr;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] free_bit;
  logic [WORD_BITS-1:0] grant_bit;
  logic [CMP_W-1:0]     limit;
  logic                 in_store;
  logic                 done;
  eval_t                eval;

  assign accept = start && (state_r == FSM_IDLE);
  assign busy   = (state_r != FSM_IDLE);
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_TOTAL);
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_TOTAL) ? CFG_DW'(total_r) : '0;

  assign limit = (CMP_W'(total_r) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                         : CMP_W'(total_r);
  assign word      = valid_r[addr_r] ? ram_rdata : '0;
  assign in_store  = CMP_W'(bn_r) < CMP_W'(MAX_BLOCKS);
  assign free_bit  = WORD_BITS'(1) << bn_r[BIT_W-1:0];
  assign grant_bit = WORD_BITS'(1) << eval.idx;

  bba_word_eval u_eval (
    .word_addr (addr_r),
    .word_data (word),
    .limit     (limit),
    .eval      (eval)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    done = 1'b0;
    if (state_r == FSM_SCAN) begin
      done = (mode_r == MODE_FREE) || eval.found || eval.last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (done) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    addr_nxt      = addr_r;
    ram_we        = 1'b0;
    ram_wdata     = word;
    out_valid_nxt = 1'b0;
    granted_nxt   = '0;
    status_nxt    = STATUS_OK;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          addr_nxt = (in_mode == MODE_FREE) ? WORD_AW'(in_block_number >> BIT_W) : '0;
        end
      end
      FSM_SCAN: begin
        if (mode_r == MODE_FREE) begin
          out_valid_nxt = 1'b1;
          if (in_store && word[bn_r[BIT_W-1:0]]) begin
            ram_we    = 1'b1;
            ram_wdata = word & ~free_bit;
          end else begin
            status_nxt = STATUS_DFREE;
          end
        end else if (eval.found) begin
          out_valid_nxt = 1'b1;
          ram_we        = 1'b1;
          ram_wdata     = word | grant_bit;
          granted_nxt   = BLOCK_W'({addr_r, eval.idx});
        end else if (eval.last) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_FULL;
        end else begin
          addr_nxt = addr_r + WORD_AW'(1);
        end
      end
      default: addr_nxt = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      total_r     <= TOTAL_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        total_r <= pwdata[TOTAL_W-1:0];
      end
      if (ram_we) begin
        valid_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (accept) begin
      mode_r <= in_mode;
      bn_r   <= in_block_number;
    end
    if (out_valid_nxt) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = granted_r;
  assign out_status        = status_r;

endmodule

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bba_word_eval.sv
// ----------------------------------------------------------------------------
// bba_word_eval
// Finds the lowest free bit of one bitmap word below the block count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_word_eval
  import bba_pkg::*;
(
  input  logic [WORD_AW-1:0]   word_addr,
  input  logic [WORD_BITS-1:0] word_data,
  input  logic [CMP_W-1:0]     limit,
  output eval_t                eval
);

  logic [CMP_W-1:0]     base;
  logic [CMP_W-1:0]     next_base;
  logic [CMP_W-1:0]     diff;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS-1:0] free_vec;

  always_comb begin
    base      = CMP_W'({word_addr, {BIT_W{1'b0}}});
    next_base = base + CMP_W'(WORD_BITS);
    diff      = limit - base;
    if (limit <= base) begin
      cnt = '0;
    end else if (diff >= CMP_W'(WORD_BITS)) begin
      cnt = CNT_W'(WORD_BITS);
    end else begin
      cnt = diff[CNT_W-1:0];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      free_vec[j] = !word_data[j] && (CNT_W'(j) < cnt);
    end
  end

  always_comb begin
    eval.found = |free_vec;
    eval.last  = next_base >= limit;
    eval.idx   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        eval.idx = BIT_W'(j);
      end
    end
  end

endmodule

FILE: rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [BLOCK_W-1:0]  out_granted_block,
  input logic [STATUS_W-1:0] out_status
);

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_IMPL(a_done_strobe, clk, rst_n, $fell(busy), out_valid, "busy fell without a result")
  `ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_valid, !busy && $past(busy), "result outside an item")
  `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && (out_status != STATUS_OK), out_granted_block == '0, "failed request with nonzero block")
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status != STATUS_BAD, "undefined status code")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_granted_block (out_granted_block),
  .out_status        (out_status)
);
